[rtl/core/reader_writer_lock_table_defines.svh]
// Assertion helpers used by the lock table controller.
`ifndef READER_WRITER_LOCK_TABLE_DEFINES_SVH
`define READER_WRITER_LOCK_TABLE_DEFINES_SVH

// Clocked property check, disabled while reset is asserted.
`define RWLT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication check: when cond holds, expect must hold on the next clock.
`define RWLT_ASSERT_NEXT(label, clk, rst_n, cond, expect_next, msg) \
    `RWLT_ASSERT(label, clk, rst_n, (cond) |=> (expect_next), msg)

`endif

[rtl/core/rwlt_pkg.sv]
`default_nettype none

package rwlt_pkg;

    // Field widths of the request and result items.
    localparam int CMD_W       = 3;
    localparam int LOCK_ID_W   = 4;
    localparam int THREAD_ID_W = 4;
    localparam int STATUS_W    = 3;

    // Number of distinct lock and thread identifiers a request can carry.
    localparam int LOCK_IDS   = 1 << LOCK_ID_W;
    localparam int THREAD_IDS = 1 << THREAD_ID_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_RD_LOCK = 3'd0,
        CMD_WR_LOCK = 3'd1,
        CMD_TRY_RD  = 3'd2,
        CMD_TRY_WR  = 3'd3,
        CMD_UNLOCK  = 3'd4,
        CMD_DESTROY = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 3'd0,
        STS_DEADLOCK  = 3'd1,
        STS_BUSY      = 3'd2,
        STS_WAIT      = 3'd3,
        STS_NOT_OWNER = 3'd4,
        STS_OVERFLOW  = 3'd5
    } t_status;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the request and read its count entry
        logic commit;  // evaluate, write back and register the status
    } t_dp_cmd;

endpackage

`default_nettype wire

[rtl/core/rwlt_dp.sv]
`default_nettype none

module rwlt_dp #(
    parameter int NUM_LOCKS   = 16,
    parameter int NUM_THREADS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire rwlt_pkg::t_dp_cmd                i_cmd,
    input  wire logic [rwlt_pkg::CMD_W-1:0]       i_req_cmd,
    input  wire logic [rwlt_pkg::LOCK_ID_W-1:0]   i_lock_id,
    input  wire logic [rwlt_pkg::THREAD_ID_W-1:0] i_thread_id,
    output logic      [rwlt_pkg::STATUS_W-1:0]    o_status
);
    import rwlt_pkg::*;

    // Only locks and threads that a request can name get storage.
    localparam int LOCK_DEPTH = (NUM_LOCKS < LOCK_IDS) ? NUM_LOCKS : LOCK_IDS;
    localparam int THR_DEPTH  = (NUM_THREADS < THREAD_IDS) ? NUM_THREADS : THREAD_IDS;
    localparam int LK_AW      = (LOCK_DEPTH > 1) ? $clog2(LOCK_DEPTH) : 1;
    localparam int CNT_DEPTH  = LOCK_DEPTH * THR_DEPTH;
    localparam int CA_W       = (CNT_DEPTH > 1) ? $clog2(CNT_DEPTH) : 1;
    localparam int RDR_W      = $clog2(THR_DEPTH + 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // Per-lock state.
    logic                   r_wheld [LOCK_DEPTH];
    logic [THREAD_ID_W-1:0] r_wthr  [LOCK_DEPTH];
    logic [RDR_W-1:0]       r_rdrs  [LOCK_DEPTH];

    // Read counts per lock and thread, with a valid bit per entry so that
    // reset needs no sweep of the memory.
    logic [COUNT_BITS-1:0]  r_cnt_mem [CNT_DEPTH];
    logic [CNT_DEPTH-1:0]   r_cnt_vld;

    // Captured request.
    logic [CMD_W-1:0]       r_cmd;
    logic [LOCK_ID_W-1:0]   r_lk;
    logic [THREAD_ID_W-1:0] r_th;
    logic                   r_ok;
    logic [CA_W-1:0]        r_addr;
    logic [COUNT_BITS-1:0]  r_rd_cnt;
    logic                   r_rd_vld;
    logic [STATUS_W-1:0]    r_status;

    logic                   in_ok;
    logic [31:0]            addr_full;
    logic [CA_W-1:0]        addr_a;

    logic [LK_AW-1:0]       li;
    logic                   wh;
    logic [THREAD_ID_W-1:0] wt;
    logic [RDR_W-1:0]       rdr;
    logic [COUNT_BITS-1:0]  cnt;
    logic [COUNT_BITS-1:0]  cnt_dec;
    logic                   own_w;
    logic                   writer;
    logic                   wait_ok;

    t_status                st;
    logic                   we_cnt;
    logic [COUNT_BITS-1:0]  n_cnt;
    logic                   we_lock;
    logic                   n_wh;
    logic [THREAD_ID_W-1:0] n_wt;
    logic                   we_rdr;
    logic [RDR_W-1:0]       n_rdr;

    // Count address of the incoming request.
    always_comb begin
        in_ok     = (32'(i_lock_id) < NUM_LOCKS) && (32'(i_thread_id) < NUM_THREADS);
        addr_full = 32'(i_lock_id) * THR_DEPTH + 32'(i_thread_id);
        addr_a    = in_ok ? addr_full[CA_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd    <= i_req_cmd;
            r_lk     <= i_lock_id;
            r_th     <= i_thread_id;
            r_ok     <= in_ok;
            r_addr   <= addr_a;
            r_rd_cnt <= r_cnt_mem[addr_a];
            r_rd_vld <= r_cnt_vld[addr_a];
        end
        if (i_cmd.commit && we_cnt) begin
            r_cnt_mem[r_addr] <= n_cnt;
        end
        if (i_cmd.commit) begin
            r_status <= st;
        end
    end

    // Lock entry and count seen by the captured request.
    always_comb begin
        li      = r_ok ? r_lk[LK_AW-1:0] : '0;
        wh      = r_wheld[li];
        wt      = r_wthr[li];
        rdr     = r_rdrs[li];
        cnt     = r_rd_vld ? r_rd_cnt : '0;
        cnt_dec = cnt - COUNT_BITS'(1);
        own_w   = wh && (wt == r_th);
        writer  = (r_cmd == CMD_WR_LOCK) || (r_cmd == CMD_TRY_WR);
        wait_ok = (r_cmd == CMD_RD_LOCK) || (r_cmd == CMD_WR_LOCK);
    end

    always_comb begin
        st      = STS_BUSY;
        we_cnt  = 1'b0;
        n_cnt   = cnt;
        we_lock = 1'b0;
        n_wh    = wh;
        n_wt    = wt;
        we_rdr  = 1'b0;
        n_rdr   = rdr;
        if (r_ok) begin
            case (r_cmd)
                CMD_RD_LOCK, CMD_WR_LOCK, CMD_TRY_RD, CMD_TRY_WR: begin
                    if (own_w || (writer && cnt != '0)) begin
                        st = STS_DEADLOCK;
                    end else if (wh || (writer && rdr != '0)) begin
                        st = wait_ok ? STS_WAIT : STS_BUSY;
                    end else if (writer) begin
                        st      = STS_OK;
                        we_lock = 1'b1;
                        n_wh    = 1'b1;
                        n_wt    = r_th;
                    end else if (cnt == '0) begin
                        st     = STS_OK;
                        we_cnt = 1'b1;
                        n_cnt  = COUNT_BITS'(1);
                        we_rdr = 1'b1;
                        n_rdr  = rdr + RDR_W'(1);
                    end else if (cnt == CNT_MAX) begin
                        st = STS_OVERFLOW;
                    end else begin
                        st     = STS_OK;
                        we_cnt = 1'b1;
                        n_cnt  = cnt + COUNT_BITS'(1);
                    end
                end
                CMD_UNLOCK: begin
                    if (own_w) begin
                        st      = STS_OK;
                        we_lock = 1'b1;
                        n_wh    = 1'b0;
                        n_wt    = '0;
                    end else if (cnt == '0) begin
                        st = STS_NOT_OWNER;
                    end else begin
                        st     = STS_OK;
                        we_cnt = 1'b1;
                        n_cnt  = cnt_dec;
                        // The last release of this thread drops it as a reader.
                        if (cnt_dec == '0 && rdr != '0) begin
                            we_rdr = 1'b1;
                            n_rdr  = rdr - RDR_W'(1);
                        end
                    end
                end
                CMD_DESTROY: begin
                    st = (wh || rdr != '0) ? STS_BUSY : STS_OK;
                end
                default: begin
                    st = STS_BUSY;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheld   <= '{default: 1'b0};
            r_wthr    <= '{default: '0};
            r_rdrs    <= '{default: '0};
            r_cnt_vld <= '0;
        end else if (i_cmd.commit) begin
            if (we_lock) begin
                r_wheld[li] <= n_wh;
                r_wthr[li]  <= n_wt;
            end
            if (we_rdr) begin
                r_rdrs[li] <= n_rdr;
            end
            if (we_cnt) begin
                r_cnt_vld[r_addr] <= 1'b1;
            end
        end
    end

    assign o_status = r_status;

endmodule

`default_nettype wire

[rtl/core/rwlt_ctrl.sv]
`default_nettype none
`include "reader_writer_lock_table_defines.svh"

module rwlt_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_valid,
    output logic                   o_s_ready,
    output logic                   o_m_valid,
    input  wire logic              i_m_ready,
    output rwlt_pkg::t_dp_cmd      o_cmd
);
    import rwlt_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   n_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_out_vld = r_out_vld;
        o_s_ready = 1'b0;
        o_cmd     = '0;
        if (r_out_vld && i_m_ready) begin
            n_out_vld = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                o_s_ready  = 1'b1;
                o_cmd.load = i_s_valid;
                if (i_s_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // Finish only when the result register is free or draining.
                if (!r_out_vld || i_m_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_vld    = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_m_valid = r_out_vld;

    `RWLT_ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n, i_s_valid && o_s_ready, r_state == S_EXEC, "accepted item did not enter execution")
    `RWLT_ASSERT_NEXT(a_commit_shows_result, i_clk, i_rst_n, o_cmd.commit, r_out_vld && r_state == S_IDLE, "committed item produced no result")
    `RWLT_ASSERT_NEXT(a_exec_holds, i_clk, i_rst_n, r_state == S_EXEC && !o_cmd.commit, r_state == S_EXEC && r_out_vld, "stalled item left execution")
    `RWLT_ASSERT(a_no_load_in_exec, i_clk, i_rst_n, !(o_cmd.load && o_cmd.commit), "load and commit in the same cycle")

endmodule

`default_nettype wire

[rtl/core/reader_writer_lock_table.sv]
// Each item is captured with its count memory read, then evaluated, written back and its
// status registered in the execute step; a new item is taken only after that write-back.
// An untaken status item lets the next item be accepted but holds it in its execute step.
// Reset: synchronous, active low; clears lock state and count valid bits,
// so the block takes items right after reset with no memory clearing pass.
`default_nettype none

module reader_writer_lock_table #(
    parameter int NUM_LOCKS   = 16,
    parameter int NUM_THREADS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Request items.
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,   // cmd[2:0], lock_id[6:3], thread_id[10:7]
    // Status items.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata    // status[2:0]
);
    import rwlt_pkg::*;

    // The controller sequences each item through two steps: capture with
    // the count memory read, then evaluate and write back. The datapath
    // holds the lock table, the per-thread read counts and the status
    // register that faces the output.

    t_dp_cmd             dp_cmd;
    logic [STATUS_W-1:0] status;

    rwlt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_cmd     (dp_cmd)
    );

    rwlt_dp #(
        .NUM_LOCKS   (NUM_LOCKS),
        .NUM_THREADS (NUM_THREADS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_req_cmd   (i_s_axis_tdata[2:0]),
        .i_lock_id   (i_s_axis_tdata[6:3]),
        .i_thread_id (i_s_axis_tdata[10:7]),
        .o_status    (status)
    );

    // Status in the low bits, the rest of the byte is zero.
    assign o_m_axis_tdata = {5'b0, status};

endmodule

`default_nettype wire
